>>> src/spwm_pkg.sv
// ----------------------------------------------------------------------------
// spwm_pkg
// shared types, codes and defaults of the stereo pan / width / peak mixer
// ----------------------------------------------------------------------------
`default_nettype none

package spwm_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 16;

  // register index port width, one code per register
  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PAN    = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_VOLUME = 2'd2,
    REG_BYPASS = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FUNC_PROC  = 2'd0,
    FUNC_CLR_L = 2'd1,
    FUNC_CLR_R = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // multiplier schedule, one product per step
  localparam int N_MUL    = 8;
  localparam int MUL_OP_W = 3;
  localparam int STEP_W   = 4;

  typedef enum logic [MUL_OP_W-1:0] {
    M_GL_IL = 3'd0,  // left pan weight * left input
    M_GR_IR = 3'd1,  // right pan weight * right input
    M_WP_WL = 3'd2,  // (1+w) * weighted left
    M_WM_WR = 3'd3,  // (1-w) * weighted right, closes left mix
    M_WP_WR = 3'd4,  // (1+w) * weighted right
    M_WM_WL = 3'd5,  // (1-w) * weighted left, closes right mix
    M_V_ML  = 3'd6,  // volume * left mix
    M_V_MR  = 3'd7   // volume * right mix
  } mul_op_e;

  typedef struct packed {
    logic    load;     // latch the accepted item
    logic    mul_en;   // issue a product
    mul_op_e mul_op;
    logic    cons_en;  // consume the registered product
    mul_op_e cons_op;
    logic    fin;      // write the result register and update peaks
  } dp_cmd_t;

endpackage

`default_nettype wire

>>> src/spwm_ctrl.sv
// ----------------------------------------------------------------------------
// spwm_ctrl
// sequencer for the shared multiplier, input handshake and result valid
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_ctrl
  import spwm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire logic    need_calc_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;
  logic [STEP_W-1:0] step_m1;

  assign step_m1 = step_q - STEP_W'(1);

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_op  = mul_op_e'(step_q[MUL_OP_W-1:0]);
    cmd_o.cons_op = mul_op_e'(step_m1[MUL_OP_W-1:0]);
    in_ready_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CALC: begin
        cmd_o.mul_en  = (step_q < STEP_W'(N_MUL));
        cmd_o.cons_en = (step_q != '0);
      end
      ST_FIN: begin
        cmd_o.fin = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (in_valid_i) begin
            state_q <= need_calc_i ? ST_CALC : ST_FIN;
          end
        end
        ST_CALC: begin
          if (step_q == STEP_W'(N_MUL)) begin
            state_q <= ST_FIN;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        ST_FIN: begin
          if (cmd_o.fin) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/spwm_datapath.sv
// ----------------------------------------------------------------------------
// spwm_datapath
// shared multiplier, accumulator, rounding, saturation and peak meters
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_datapath
  import spwm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire dp_cmd_t                       cmd_i,
  input  wire logic [1:0]                    func_i,
  input  wire logic signed [SAMPLE_BITS-1:0] in_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0] in_right_i,
  input  wire logic [COEF_BITS-1:0]          pan_i,
  input  wire logic [COEF_BITS-1:0]          width_i,
  input  wire logic [COEF_BITS-1:0]          volume_i,
  input  wire logic                          bypass_i,
  output logic signed [SAMPLE_BITS-1:0]      out_left_o,
  output logic signed [SAMPLE_BITS-1:0]      out_right_o,
  output logic [SAMPLE_BITS-2:0]             peak_left_o,
  output logic [SAMPLE_BITS-2:0]             peak_right_o
);

  localparam int S    = SAMPLE_BITS;
  localparam int C    = COEF_BITS;
  localparam int AW   = C + 2;
  localparam int BW   = S + 2;
  localparam int PW   = AW + BW;
  localparam int SUMW = PW + 2;

  localparam logic [C:0] ONE_C = {1'b1, {C{1'b0}}};
  localparam logic [C-1:0] HALF_C = {1'b1, {(C-1){1'b0}}};
  localparam logic [SUMW-1:0] RND_C   = {{(SUMW-C){1'b0}}, 1'b1, {(C-1){1'b0}}};
  localparam logic [SUMW-1:0] RND_C1  = {{(SUMW-C-1){1'b0}}, 1'b1, {C{1'b0}}};
  localparam logic [SUMW-1:0] RND_CM1 = {{(SUMW-C+1){1'b0}}, 1'b1, {(C-2){1'b0}}};

  func_e                 func_q;
  logic signed [S-1:0]   il_q, ir_q;
  logic signed [BW-1:0]  wl_q, wr_q, ml_q, mr_q;
  logic signed [PW-1:0]  prod_q, acc_q;
  logic signed [S-1:0]   l_q, r_q;
  logic signed [S-1:0]   out_l_q, out_r_q;
  logic [S-2:0]          peak_l_q, peak_r_q;

  logic [C:0]            gl, gr, wp, wm;
  logic signed [AW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic signed [SUMW-1:0] sum_s, t_c, t_c1, t_cm1, r_c, r_c1, r_cm1;
  logic signed [S-1:0]   sat_v;
  logic [SUMW-S:0]       sat_hi;

  // pan law weights and width factors, all unsigned Q1.C
  always_comb begin
    gl = (pan_i > HALF_C) ? ((ONE_C - {1'b0, pan_i}) << 1) : ONE_C;
    gr = (pan_i < HALF_C) ? {pan_i, 1'b0} : ONE_C;
    wp = {1'b1, width_i};
    wm = ONE_C - {1'b0, width_i};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_op)
      M_GL_IL: begin mul_a = $signed({1'b0, gl}); mul_b = BW'(il_q); end
      M_GR_IR: begin mul_a = $signed({1'b0, gr}); mul_b = BW'(ir_q); end
      M_WP_WL: begin mul_a = $signed({1'b0, wp}); mul_b = wl_q; end
      M_WM_WR: begin mul_a = $signed({1'b0, wm}); mul_b = wr_q; end
      M_WP_WR: begin mul_a = $signed({1'b0, wp}); mul_b = wr_q; end
      M_WM_WL: begin mul_a = $signed({1'b0, wm}); mul_b = wl_q; end
      M_V_ML:  begin mul_a = $signed({2'b00, volume_i}); mul_b = ml_q; end
      M_V_MR:  begin mul_a = $signed({2'b00, volume_i}); mul_b = mr_q; end
      default: ;
    endcase
  end

  // round half up is an add of half an lsb and an arithmetic shift
  always_comb begin
    if (cmd_i.cons_op == M_WM_WR || cmd_i.cons_op == M_WM_WL) begin
      sum_s = SUMW'(acc_q) + SUMW'(prod_q);
    end else begin
      sum_s = SUMW'(prod_q);
    end
    t_c   = sum_s + $signed(RND_C);
    t_c1  = sum_s + $signed(RND_C1);
    t_cm1 = sum_s + $signed(RND_CM1);
    r_c   = t_c >>> C;
    r_c1  = t_c1 >>> (C + 1);
    r_cm1 = t_cm1 >>> (C - 1);
    sat_hi = r_cm1[SUMW-1:S-1];
    if (&sat_hi || ~|sat_hi) begin
      sat_v = r_cm1[S-1:0];
    end else if (r_cm1[SUMW-1]) begin
      sat_v = $signed({1'b1, {(S-1){1'b0}}});
    end else begin
      sat_v = $signed({1'b0, {(S-1){1'b1}}});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      il_q   <= in_left_i;
      ir_q   <= in_right_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.cons_en) begin
      case (cmd_i.cons_op)
        M_GL_IL: wl_q  <= r_c[BW-1:0];
        M_GR_IR: wr_q  <= r_c[BW-1:0];
        M_WP_WL: acc_q <= prod_q;
        M_WM_WR: ml_q  <= r_c1[BW-1:0];
        M_WP_WR: acc_q <= prod_q;
        M_WM_WL: mr_q  <= r_c1[BW-1:0];
        M_V_ML:  l_q   <= sat_v;
        M_V_MR:  r_q   <= sat_v;
        default: ;
      endcase
    end
    if (cmd_i.fin) begin
      if (func_q == FUNC_PROC) begin
        out_l_q <= bypass_i ? il_q : l_q;
        out_r_q <= bypass_i ? ir_q : r_q;
      end else begin
        out_l_q <= '0;
        out_r_q <= '0;
      end
    end
  end

  // peak meters only see positive processed samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_l_q <= '0;
      peak_r_q <= '0;
    end else if (cmd_i.fin) begin
      case (func_q)
        FUNC_PROC: begin
          if (!bypass_i) begin
            if (!l_q[S-1] && (l_q[S-2:0] > peak_l_q)) peak_l_q <= l_q[S-2:0];
            if (!r_q[S-1] && (r_q[S-2:0] > peak_r_q)) peak_r_q <= r_q[S-2:0];
          end
        end
        FUNC_CLR_L: peak_l_q <= '0;
        FUNC_CLR_R: peak_r_q <= '0;
        default: ;
      endcase
    end
  end

  assign out_left_o   = out_l_q;
  assign out_right_o  = out_r_q;
  assign peak_left_o  = peak_l_q;
  assign peak_right_o = peak_r_q;

endmodule

`default_nettype wire

>>> src/stereo_pan_width_peak_mixer.sv
// ----------------------------------------------------------------------------
// stereo_pan_width_peak_mixer
// pan law, stereo width mix, master volume and positive peak meters
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake            payload
//   s_axis    in   tvalid/tready        tdata: in_left, in_right; tuser: func
//   m_axis    out  tvalid/tready        tdata: out_left, out_right, peak_l, peak_r
//   cfg       in   cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
// a processed frame goes from its accept through eight products on the one
// shared multiplier, a step that consumes the last product, and a finish
// that loads the result register; the input stays closed until the finish
// bypass, clear and unused items go from the accept straight to the finish
// a result waiting in the output register does not block the next accept;
// the finish cycle waits until the output register is free
// reset clears the sequencer, the valid flag, the peaks and the config registers
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_pan_width_peak_mixer
  import spwm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = COEF_BITS_DEF,
  localparam int IN_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((4 * SAMPLE_BITS - 2 + 7) / 8) * 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // stream in
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [IN_W-1:0]      s_axis_tdata_i,   // in_left, in_right, zero pad
  input  wire logic [1:0]           s_axis_tuser_i,   // func
  // stream out
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [OUT_W-1:0]          m_axis_tdata_o,   // out_left, out_right,
                                                      // peak_left, peak_right, zero pad
  // register writes
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COEF_BITS-1:0] cfg_wdata_i
);

  localparam int S = SAMPLE_BITS;
  localparam int C = COEF_BITS;

  // configuration registers
  logic [C-1:0] pan_q, width_q, volume_q;
  logic         bypass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q    <= {1'b1, {(C-1){1'b0}}};  // centre
      width_q  <= '1;                      // full stereo
      volume_q <= {1'b1, {(C-1){1'b0}}};  // unity
      bypass_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PAN:    pan_q    <= cfg_wdata_i;
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_VOLUME: volume_q <= cfg_wdata_i;
        REG_BYPASS: bypass_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  dp_cmd_t             cmd;
  logic                need_calc;
  logic signed [S-1:0] out_left, out_right;
  logic [S-2:0]        peak_left, peak_right;

  // only a process frame outside bypass goes through the multiplier
  assign need_calc = (func_e'(s_axis_tuser_i) == FUNC_PROC) && !bypass_q;

  spwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .need_calc_i (need_calc),
    .cmd_o       (cmd)
  );

  spwm_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .func_i       (s_axis_tuser_i),
    .in_left_i    ($signed(s_axis_tdata_i[S-1:0])),
    .in_right_i   ($signed(s_axis_tdata_i[2*S-1:S])),
    .pan_i        (pan_q),
    .width_i      (width_q),
    .volume_i     (volume_q),
    .bypass_i     (bypass_q),
    .out_left_o   (out_left),
    .out_right_o  (out_right),
    .peak_left_o  (peak_left),
    .peak_right_o (peak_right)
  );

  assign m_axis_tdata_o = OUT_W'({peak_right, peak_left, out_right, out_left});

endmodule

`default_nettype wire

>>> src/spwm_checker.sv
// ----------------------------------------------------------------------------
// spwm_checker
// port level checks of the mixer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_checker
  import spwm_pkg::*;
#(
  parameter int OUT_W = 96
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire logic [OUT_W-1:0] m_axis_tdata_o
);

  // a stalled result keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result valid dropped under stall");

  // a stalled result keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed under stall");

  // one item at a time: accepting an item closes the input
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted again while an item is in work");

  // a new result shows up together with the input reopening
  a_fin_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result appeared while the input stayed closed");

  // a result is never shown without an item having been taken
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o) || $past(s_axis_tvalid_i))
    else $error("result appeared without an accepted item");

endmodule

bind stereo_pan_width_peak_mixer spwm_checker #(
  .OUT_W (OUT_W)
) u_spwm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
